[rtl/cmdl_pkg.sv]
`default_nettype none
package cmdl_pkg;

    localparam int LINE_BYTES = 42;
    localparam int POS_W      = $clog2(LINE_BYTES);

    localparam int KW_COUNT   = 7;
    localparam int KW_EXACT   = 5;
    localparam int KW_MAX_LEN = 18;
    localparam int KW_IDX_W   = $clog2(KW_MAX_LEN);

    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "MEASUREMENT START",
        "MEASUREMENT STOP",
        "MEMORY ERASE",
        "MEMORY READ",
        "GET STATE",
        "SET RISING LEVEL ",
        "SET FALLING LEVEL "
    };

    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
        POS_W'(17), POS_W'(16), POS_W'(12), POS_W'(11),
        POS_W'(9), POS_W'(17), POS_W'(18)
    };

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [31:0] ACC_LIMIT = 32'd429496729;
    localparam logic [3:0]  LAST_DIG  = 4'd5;

    typedef enum logic [2:0] {
        CMD_UNKNOWN     = 3'd0,
        CMD_MEAS_START  = 3'd1,
        CMD_MEAS_STOP   = 3'd2,
        CMD_MEM_ERASE   = 3'd3,
        CMD_MEM_READ    = 3'd4,
        CMD_STATE_QUERY = 3'd5,
        CMD_SET_RISING  = 3'd6,
        CMD_SET_FALLING = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        PH_BLANK = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_STOP  = 2'd3
    } t_num_phase;

    typedef struct packed {
        logic term;
        logic feed;
        logic restart;
        t_cmd exact_cmd;
        t_cmd prefix_cmd;
    } t_match_st;

endpackage
`default_nettype wire

[rtl/cmdl_kw_match.sv]
`default_nettype none
module cmdl_kw_match
    import cmdl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_byte,
    output t_match_st       o_st
);

    logic [POS_W-1:0]    r_pos, n_pos;
    logic [KW_COUNT-1:0] r_flags, n_flags;
    logic                r_cut, n_cut;

    logic                term;
    logic                feed;
    logic                restart;
    t_cmd                exact_cmd;
    t_cmd                prefix_cmd;
    logic [KW_IDX_W-1:0] offs;
    logic [7:0]          kw_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_flags <= '1;
            r_cut   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_flags <= n_flags;
            r_cut   <= n_cut;
        end
    end

    always_comb begin
        term       = (i_byte == CH_LF) || (i_byte == CH_CR);
        exact_cmd  = CMD_UNKNOWN;
        prefix_cmd = CMD_UNKNOWN;
        for (int k = KW_EXACT - 1; k >= 0; k--) begin
            if (r_flags[k] && (r_cut || r_pos == KW_LEN[k])) begin
                exact_cmd = t_cmd'(3'(k + 1));
            end
        end
        for (int k = KW_COUNT - 1; k >= KW_EXACT; k--) begin
            if (r_flags[k]) begin
                prefix_cmd = t_cmd'(3'(k + 1));
            end
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_flags = r_flags;
        n_cut   = r_cut;
        feed    = 1'b0;
        restart = 1'b0;
        offs    = '0;
        kw_ch   = '0;
        if (i_en) begin
            if (term) begin
                n_pos   = '0;
                restart = 1'b1;
            end else begin
                if (!r_cut) begin
                    if (i_byte == CH_NUL) begin
                        for (int k = 0; k < KW_COUNT; k++) begin
                            if ((k < KW_EXACT) ? (r_pos != KW_LEN[k])
                                               : (r_pos < KW_LEN[k])) begin
                                n_flags[k] = 1'b0;
                            end
                        end
                        n_cut = 1'b1;
                    end else begin
                        for (int k = 0; k < KW_COUNT; k++) begin
                            if (r_flags[k]) begin
                                if (r_pos < KW_LEN[k]) begin
                                    offs  = KW_IDX_W'(KW_LEN[k] - r_pos - POS_W'(1));
                                    kw_ch = KW_TEXT[k][{offs, 3'b000} +: 8];
                                    if (kw_ch != i_byte) begin
                                        n_flags[k] = 1'b0;
                                    end
                                end else if (k < KW_EXACT) begin
                                    n_flags[k] = 1'b0;
                                end else begin
                                    feed = 1'b1;
                                end
                            end
                        end
                    end
                end
                if (r_pos == POS_W'(LINE_BYTES - 1)) begin
                    n_pos   = '0;
                    restart = 1'b1;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
            if (restart) begin
                n_flags = '1;
                n_cut   = 1'b0;
            end
        end
    end

    always_comb begin
        o_st.term       = i_en && term;
        o_st.feed       = feed;
        o_st.restart    = restart;
        o_st.exact_cmd  = exact_cmd;
        o_st.prefix_cmd = prefix_cmd;
    end

endmodule
`default_nettype wire

[rtl/cmdl_num_parse.sv]
`default_nettype none
module cmdl_num_parse
    import cmdl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_feed,
    input  wire logic        i_restart,
    input  wire logic        i_load,
    output logic             o_has_digit,
    output logic [31:0]      o_number
);

    t_num_phase  r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_ovf, n_ovf;
    logic        r_has, n_has;
    logic [31:0] r_last, n_last;

    logic        is_digit;
    logic [3:0]  dig;
    logic [31:0] value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BLANK;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
            r_has   <= 1'b0;
            r_last  <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_ovf   <= n_ovf;
            r_has   <= n_has;
            r_last  <= n_last;
        end
    end

    always_comb begin
        is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        dig      = 4'(i_byte - CH_ZERO);
        if (r_ovf) begin
            value = '1;
        end else if (r_neg) begin
            value = 32'd0 - r_acc;
        end else begin
            value = r_acc;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_ovf   = r_ovf;
        n_has   = r_has;
        if (i_restart) begin
            n_phase = PH_BLANK;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_ovf   = 1'b0;
            n_has   = 1'b0;
        end else if (i_feed && r_phase != PH_STOP) begin
            if (is_digit) begin
                n_has   = 1'b1;
                n_phase = PH_DIGIT;
                if (!r_ovf) begin
                    if (r_acc > ACC_LIMIT || (r_acc == ACC_LIMIT && dig > LAST_DIG)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + 32'(dig);
                    end
                end
            end else if (r_phase == PH_BLANK) begin
                case (i_byte)
                    CH_TAB, CH_VT, CH_FF, CH_SPACE: n_phase = PH_BLANK;
                    CH_PLUS:  n_phase = PH_SIGN;
                    CH_MINUS: begin
                        n_phase = PH_SIGN;
                        n_neg   = 1'b1;
                    end
                    default:  n_phase = PH_STOP;
                endcase
            end else begin
                n_phase = PH_STOP;
            end
        end
    end

    always_comb begin
        n_last      = i_load ? value : r_last;
        o_has_digit = r_has;
        o_number    = n_last;
    end

endmodule
`default_nettype wire

[rtl/text_command_line_decoder.sv]
`default_nettype none
// Text command line decoder.
// Slave channel (i_s_*): one received character per item in s_tdata[7:0].
// Master channel (o_m_*): one item per line terminator (LF or CR) with the
// command code in m_tdata[2:0] and the last decoded number in m_tdata[34:3].
// Other characters give no item; they advance the keyword matcher and the
// decimal argument parser.
// A terminator is accepted into the input register, decoded from there, and
// its item is driven on the master side from the result register.
// Throughput: one character per cycle unless the master side stalls, with
// an input register and a result register around the matcher.
// A result waiting on the master side does not block the next character;
// only when both the input register and the result register are full and
// the receiver stalls does s_tready drop.
// Reset (synchronous, active low) empties both registers, clears the line
// position, re-arms all keywords and sets the stored number to zero.
module text_command_line_decoder
    import cmdl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata    // [2:0] command, [34:3] number, [39:35] zero
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_cmd        r_cmd;
    logic [31:0] r_num;

    logic        adv;
    logic        proc;
    logic        s_acc;
    logic        has_digit;
    logic        load;
    logic [31:0] number;
    t_cmd        n_cmd;
    t_match_st   mst;

    assign adv        = !r_out_valid || i_m_tready;
    assign proc       = r_in_valid && adv;
    assign o_s_tready = !r_in_valid || adv;
    assign s_acc      = i_s_tvalid && o_s_tready;

    cmdl_kw_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc),
        .i_byte  (r_in_byte),
        .o_st    (mst)
    );

    cmdl_num_parse u_num (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (r_in_byte),
        .i_feed      (mst.feed),
        .i_restart   (mst.restart),
        .i_load      (load),
        .o_has_digit (has_digit),
        .o_number    (number)
    );

    always_comb begin
        load  = 1'b0;
        n_cmd = CMD_UNKNOWN;
        if (mst.exact_cmd != CMD_UNKNOWN) begin
            n_cmd = mst.exact_cmd;
        end else if (mst.prefix_cmd != CMD_UNKNOWN && has_digit) begin
            n_cmd = mst.prefix_cmd;
            load  = mst.term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= mst.term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_byte <= i_s_tdata;
        end
        if (mst.term) begin
            r_cmd <= n_cmd;
            r_num <= number;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b00000, r_num, r_cmd};

endmodule
`default_nettype wire

[rtl/cmdl_checker.sv]
`default_nettype none
module cmdl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [7:0]  i_s_tdata,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata
);

    a_rst_out_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result item present after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without an output stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result item changed");

endmodule

bind text_command_line_decoder cmdl_checker u_cmdl_checker (.*);
`default_nettype wire
